// ===== src/pld_pkg.sv =====
// ----------------------------------------------------------------------------
// pld_pkg: shared types and constants for the load decay core
// Decay fraction table (y^n, y^32 = 1/2, 0.32 fixed point) and stage payloads.
// ----------------------------------------------------------------------------
package pld_pkg;

    localparam logic [31:0] SeriesLimit = 32'd47742;
    localparam logic [31:0] PeriodUnit  = 32'd1024;
    localparam logic        FuncDecay   = 1'b0;
    localparam logic        FuncAccum   = 1'b1;

    // stage 1 -> stage 2: operands for the two multipliers
    typedef struct packed {
        logic        func;
        logic [31:0] op_a;
        logic [31:0] op_b;
        logic [31:0] frac;
        logic [10:0] last_part;
    } prep_t;

    // stage 2 -> stage 3: registered products
    typedef struct packed {
        logic        func;
        logic [63:0] prod_a;
        logic [63:0] prod_b;
        logic [10:0] last_part;
    } prod_t;

    function automatic logic [31:0] y_pow_frac(input logic [4:0] idx);
        logic [31:0] f;
        case (idx)
            5'd0:    f = 32'hffffffff;
            5'd1:    f = 32'hfa83b2da;
            5'd2:    f = 32'hf5257d14;
            5'd3:    f = 32'hefe4b99a;
            5'd4:    f = 32'heac0c6e6;
            5'd5:    f = 32'he5b906e6;
            5'd6:    f = 32'he0ccdeeb;
            5'd7:    f = 32'hdbfbb796;
            5'd8:    f = 32'hd744fcc9;
            5'd9:    f = 32'hd2a81d91;
            5'd10:   f = 32'hce248c14;
            5'd11:   f = 32'hc9b9bd85;
            5'd12:   f = 32'hc5672a10;
            5'd13:   f = 32'hc12c4cc9;
            5'd14:   f = 32'hbd08a39e;
            5'd15:   f = 32'hb8fbaf46;
            5'd16:   f = 32'hb504f333;
            5'd17:   f = 32'hb123f581;
            5'd18:   f = 32'had583ee9;
            5'd19:   f = 32'ha9a15ab4;
            5'd20:   f = 32'ha5fed6a9;
            5'd21:   f = 32'ha2704302;
            5'd22:   f = 32'h9ef5325f;
            5'd23:   f = 32'h9b8d39b9;
            5'd24:   f = 32'h9837f050;
            5'd25:   f = 32'h94f4efa8;
            5'd26:   f = 32'h91c3d373;
            5'd27:   f = 32'h8ea4398a;
            5'd28:   f = 32'h8b95c1e3;
            5'd29:   f = 32'h88980e80;
            5'd30:   f = 32'h85aac367;
            5'd31:   f = 32'h82cd8698;
            default: f = 32'hffffffff;
        endcase
        return f;
    endfunction

endpackage

// ===== src/pld_prep.sv =====
// ----------------------------------------------------------------------------
// pld_prep: operand preparation stage
// Whole-period shift, table lookup and operand selection per mode.
// ----------------------------------------------------------------------------
module pld_prep (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           func,
    input  logic [63:0]    value,
    input  logic [31:0]    periods,
    input  logic [10:0]    first_part,
    input  logic [10:0]    last_part,
    output logic           out_valid,
    input  logic           out_ready,
    output pld_pkg::prep_t out_data
);

    logic           valid_reg;
    pld_pkg::prep_t data_reg;
    pld_pkg::prep_t data_next;
    logic [5:0]     shamt;
    logic           too_far;
    logic [63:0]    shifted;
    logic [31:0]    lim_shifted;
    logic [31:0]    d1_shifted;

    assign shamt   = periods[10:5];
    // 2048 or more periods (64 or more halvings): everything decays to zero
    assign too_far = |periods[31:11];
    assign shifted     = value >> shamt;
    assign lim_shifted = pld_pkg::SeriesLimit >> shamt;
    assign d1_shifted  = {21'b0, first_part} >> shamt;

    always_comb begin
        data_next.func      = func;
        data_next.frac      = pld_pkg::y_pow_frac(periods[4:0]);
        data_next.last_part = last_part;
        if (too_far) begin
            data_next.op_a = 32'b0;
            data_next.op_b = 32'b0;
        end else if (func == pld_pkg::FuncDecay) begin
            data_next.op_a = shifted[63:32];
            data_next.op_b = shifted[31:0];
        end else begin
            data_next.op_a = lim_shifted;
            data_next.op_b = d1_shifted;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== src/pld_mult.sv =====
// ----------------------------------------------------------------------------
// pld_mult: multiplier stage
// Two parallel 32x32 products of the operands with the decay fraction.
// ----------------------------------------------------------------------------
module pld_mult (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  pld_pkg::prep_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output pld_pkg::prod_t out_data
);

    logic           valid_reg;
    pld_pkg::prod_t data_reg;
    pld_pkg::prod_t data_next;

    always_comb begin
        data_next.func      = in_data.func;
        data_next.last_part = in_data.last_part;
        data_next.prod_a    = {32'b0, in_data.op_a} * {32'b0, in_data.frac};
        data_next.prod_b    = {32'b0, in_data.op_b} * {32'b0, in_data.frac};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== src/pld_sum.sv =====
// ----------------------------------------------------------------------------
// pld_sum: final sum stage and output register
// Combines the products into the decayed value or the segment sum.
// ----------------------------------------------------------------------------
module pld_sum (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  pld_pkg::prod_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [63:0]    result
);

    logic        valid_reg;
    logic [63:0] result_reg;
    logic [63:0] result_next;
    logic [31:0] seg_sum;

    // d1 decayed + (limit - limit decayed - unit) + d3, wraps mod 2^32
    assign seg_sum = in_data.prod_b[63:32] + pld_pkg::SeriesLimit - in_data.prod_a[63:32]
                     - pld_pkg::PeriodUnit + {21'b0, in_data.last_part};

    always_comb begin
        if (in_data.func == pld_pkg::FuncDecay) begin
            // hi*f + (lo*f >> 32) cannot overflow 64 bits
            result_next = in_data.prod_a + {32'b0, in_data.prod_b[63:32]};
        end else begin
            result_next = {32'b0, seg_sum};
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            result_reg <= result_next;
        end
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;

endmodule

// ===== src/pelt_load_decay_core.sv =====
// ----------------------------------------------------------------------------
// pelt_load_decay_core: geometric load decay unit (y^32 = 1/2)
// Usage:
//   Slave stream s_*: one transaction per item. tuser = func (0 decay,
//   1 segment accumulate); tdata packs value, periods, first_part, last_part.
//   Master stream m_*: one result transaction per accepted item, in order;
//   m_tdata is the decayed value, or the 32-bit segment sum zero-extended.
//   Three register stages: operand shift and table lookup, the two 32x32
//   multipliers, then the final add into the output register. An accepted
//   item passes the prep, product and output registers in that order before
//   m_tvalid rises. Throughput is one item per cycle while m_tready is high.
//   When the receiver holds m_tready low, items stay in their stages and
//   bubbles ahead of them are filled; s_tready drops only once all three
//   stages are full. Nothing is lost or repeated.
//   A synchronous active-low aresetn empties the pipeline; the unit keeps
//   no other state.
// ----------------------------------------------------------------------------
module pelt_load_decay_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [63:0] value, [95:64] periods, [106:96] first_part, [117:107] last_part,
    // [119:118] zero
    input  logic [119:0] s_tdata,
    // [0] func
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [63:0] result
    output logic [63:0]  m_tdata
);

    logic           prep_valid;
    logic           prep_ready;
    pld_pkg::prep_t prep_data;
    logic           prod_valid;
    logic           prod_ready;
    pld_pkg::prod_t prod_data;

    pld_prep u_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .func       (s_tuser),
        .value      (s_tdata[63:0]),
        .periods    (s_tdata[95:64]),
        .first_part (s_tdata[106:96]),
        .last_part  (s_tdata[117:107]),
        .out_valid  (prep_valid),
        .out_ready  (prep_ready),
        .out_data   (prep_data)
    );

    pld_mult u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    pld_sum u_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .result    (m_tdata)
    );

endmodule

// ===== tb/pelt_load_decay_checker.sv =====
// ----------------------------------------------------------------------------
// pelt_load_decay_checker: result checker for the load decay core
// Watches both streams. Every input transaction is turned into its expected
// decayed value or segment sum. Every result transaction is compared, in
// order, against the oldest expected value.
// ----------------------------------------------------------------------------
module pelt_load_decay_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    // [63:0] value, [95:64] periods, [106:96] first_part, [117:107] last_part
    input  logic [119:0] s_tdata,
    // [0] func
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    // [63:0] result
    input  logic [63:0]  m_tdata,
    output int           mismatches,
    output int           outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // y^n for n = 0..31, 0.32 unsigned fixed point
    logic [31:0] decay_frac [32] = '{
        32'hffffffff, 32'hfa83b2da, 32'hf5257d14, 32'hefe4b99a,
        32'heac0c6e6, 32'he5b906e6, 32'he0ccdeeb, 32'hdbfbb796,
        32'hd744fcc9, 32'hd2a81d91, 32'hce248c14, 32'hc9b9bd85,
        32'hc5672a10, 32'hc12c4cc9, 32'hbd08a39e, 32'hb8fbaf46,
        32'hb504f333, 32'hb123f581, 32'had583ee9, 32'ha9a15ab4,
        32'ha5fed6a9, 32'ha2704302, 32'h9ef5325f, 32'h9b8d39b9,
        32'h9837f050, 32'h94f4efa8, 32'h91c3d373, 32'h8ea4398a,
        32'h8b95c1e3, 32'h88980e80, 32'h85aac367, 32'h82cd8698
    };

    logic [63:0] expected_results [$];

    function automatic logic [63:0] decay_by_periods(input logic [63:0] load,
                                                     input logic [31:0] periods);
        logic [31:0] halvings;
        logic [63:0] shifted;
        logic [95:0] product;
        halvings = periods >> 5;
        if (halvings >= 32'd64)
            return 64'd0;
        shifted = load >> halvings;
        product = {32'd0, shifted} * {64'd0, decay_frac[periods[4:0]]};
        return product[95:32];
    endfunction

    function automatic logic [63:0] predict_load(input logic func,
                                                 input logic [119:0] data);
        logic [31:0] periods;
        logic [31:0] head;
        logic [31:0] middle;
        logic [31:0] segment_sum;
        periods = data[95:64];
        if (func == pld_pkg::FuncDecay)
            return decay_by_periods(data[63:0], periods);
        head = 32'(decay_by_periods({53'd0, data[106:96]}, periods));
        // wraps when periods is 0
        middle = pld_pkg::SeriesLimit
                 - 32'(decay_by_periods({32'd0, pld_pkg::SeriesLimit}, periods))
                 - pld_pkg::PeriodUnit;
        segment_sum = head + middle + {21'd0, data[117:107]};
        return {32'd0, segment_sum};
    endfunction

    always @(posedge aclk) begin : monitor
        logic [63:0] want;
        if (!aresetn) begin
            expected_results.delete();
            outstanding <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction: result %h", m_tdata);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata !== want) begin
                        $error("result mismatch: expected %h, actual %h", want, m_tdata);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_load(s_tuser, s_tdata));
            outstanding <= expected_results.size();
        end
    end

endmodule

// ===== tb/pelt_load_decay_core_tb.sv =====
// ----------------------------------------------------------------------------
// pelt_load_decay_core_tb: regression bench for the load decay core
// Directed corner items (shift limit, wrap of the segment sum, oversized
// parts, ignored fields) followed by random items, with random gaps on
// both streams, a long output stall and a full drain pause.
// ----------------------------------------------------------------------------
module pelt_load_decay_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandomItems    = 1200;
    localparam int PhaseItems     = 100;
    localparam int LongHoldCycles = 200;
    localparam int DrainCycles    = 10;
    localparam int CycleLimit     = 200000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;

    int mismatches;
    int outstanding;

    bit tx_gaps;
    bit rx_gaps;
    bit hold_request;

    pelt_load_decay_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    pelt_load_decay_checker result_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CycleLimit) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_item(input logic func, input logic [63:0] value,
                             input logic [31:0] periods, input logic [10:0] first_part,
                             input logic [10:0] last_part);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {2'b00, last_part, first_part, periods, value};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // receiver: per-result gap, plus one long hold on request
    initial begin : receiver
        int gap;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (LongHoldCycles) @(posedge aclk);
                hold_request = 1'b0;
            end
            gap = rx_gaps ? $urandom_range(0, 10) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin : stimulus
        logic        func;
        logic [63:0] value;
        logic [31:0] periods;
        logic [10:0] first_part;
        logic [10:0] last_part;

        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = pld_pkg::FuncDecay;
        tx_gaps      = 1'b1;
        rx_gaps      = 1'b1;
        hold_request = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // decay: extremes, shift limit at 64 halvings
        send_item(pld_pkg::FuncDecay, '1, 32'd0, 11'd0, 11'd0);
        send_item(pld_pkg::FuncDecay, '1, 32'd31, 11'h7ff, 11'h7ff);
        send_item(pld_pkg::FuncDecay, '1, 32'd32, 11'd0, 11'd0);
        send_item(pld_pkg::FuncDecay, '1, 32'd2047, 11'd0, 11'd0);
        send_item(pld_pkg::FuncDecay, '1, 32'd2048, 11'd0, 11'd0);
        send_item(pld_pkg::FuncDecay, '1, '1, 11'd0, 11'd0);
        send_item(pld_pkg::FuncDecay, 64'd0, 32'd5, 11'd0, 11'd0);
        send_item(pld_pkg::FuncDecay, 64'd1, 32'd0, 11'd0, 11'd0);
        send_item(pld_pkg::FuncDecay, 64'h8000_0000_0000_0000, 32'd2016, 11'd0, 11'd0);
        send_item(pld_pkg::FuncDecay, {$urandom, $urandom}, 32'd16,
                  11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)));
        // accumulate: middle term wraps with zero periods
        send_item(pld_pkg::FuncAccum, 64'd0, 32'd0, 11'd0, 11'd0);
        send_item(pld_pkg::FuncAccum, 64'd0, 32'd0, 11'd1024, 11'd1024);
        send_item(pld_pkg::FuncAccum, 64'd0, 32'd1, 11'd1024, 11'd0);
        send_item(pld_pkg::FuncAccum, 64'd0, 32'd31, 11'd512, 11'd17);
        send_item(pld_pkg::FuncAccum, 64'd0, 32'd32, 11'd1024, 11'd1024);
        send_item(pld_pkg::FuncAccum, 64'd0, 32'd2048, 11'd1024, 11'd1024);
        send_item(pld_pkg::FuncAccum, 64'd0, '1, 11'd1024, 11'd1024);
        // oversized parts are used as given
        send_item(pld_pkg::FuncAccum, 64'd0, 32'd0, 11'h7ff, 11'h7ff);
        send_item(pld_pkg::FuncAccum, 64'd0, 32'd345, 11'd1025, 11'h7ff);
        // value has no effect on accumulate
        send_item(pld_pkg::FuncAccum, '1, 32'd100, 11'd700, 11'd300);
        send_item(pld_pkg::FuncAccum, {$urandom, $urandom}, 32'd100, 11'd700, 11'd300);
        s_tvalid <= 1'b0;
        wait_drained();

        for (int n = 0; n < RandomItems; n++) begin
            if (n % PhaseItems == 0) begin
                tx_gaps = $urandom_range(0, 3) != 0;
                rx_gaps = $urandom_range(0, 3) != 0;
                if (n == 3 * PhaseItems) begin
                    // back-to-back offers against a stalled output
                    tx_gaps      = 1'b0;
                    hold_request = 1'b1;
                end
                if (n == 6 * PhaseItems) begin
                    s_tvalid <= 1'b0;
                    wait_drained();
                end
            end
            func = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0:       periods = $urandom_range(0, 63);
                1:       periods = $urandom_range(0, 2100);
                2:       periods = $urandom_range(1980, 2100);
                default: periods = $urandom;
            endcase
            case ($urandom_range(0, 2))
                0:       value = 64'($urandom_range(0, 4096));
                1:       value = ~64'd0 >> $urandom_range(0, 63);
                default: value = {$urandom, $urandom};
            endcase
            if ($urandom_range(0, 3) == 0) begin
                first_part = 11'($urandom_range(0, 2047));
                last_part  = 11'($urandom_range(0, 2047));
            end else begin
                first_part = 11'($urandom_range(0, 1024));
                last_part  = 11'($urandom_range(0, 1024));
            end
            send_item(func, value, periods, first_part, last_part);
        end
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (DrainCycles) @(posedge aclk);

        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
